// ===== rtl/sm4_pkg.sv =====
`default_nettype none
package sm4_pkg;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
		logic        mode;
		logic        restart_chain;
	} sm4_in_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} sm4_out_t;

	localparam logic [2:0] CFG_KEY_HIGH     = 3'd0;
	localparam logic [2:0] CFG_KEY_LOW      = 3'd1;
	localparam logic [2:0] CFG_IV_HIGH      = 3'd2;
	localparam logic [2:0] CFG_IV_LOW       = 3'd3;
	localparam logic [2:0] CFG_CHAINING_CBC = 3'd4;

	localparam logic [31:0] FK0 = 32'hA3B1BAC6;
	localparam logic [31:0] FK1 = 32'h56AA3350;
	localparam logic [31:0] FK2 = 32'h677D9197;
	localparam logic [31:0] FK3 = 32'hB27022DC;

	localparam logic [7:0] SBOX [256] = '{
		8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
		8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
		8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
		8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
		8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
		8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
		8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
		8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
		8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
		8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
		8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
		8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
		8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
		8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
		8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
	};

	// byte-wise sbox over a word
	function automatic logic [31:0] subst(input logic [31:0] a);
		subst = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
	endfunction

	// ck byte j of word i is (4*i + j) * 7 mod 256
	function automatic logic [31:0] ck_word(input logic [4:0] i);
		logic [7:0] b0, b1, b2, b3;
		b0 = 8'({i, 2'd0}) * 8'd7;
		b1 = 8'({i, 2'd1}) * 8'd7;
		b2 = 8'({i, 2'd2}) * 8'd7;
		b3 = 8'({i, 2'd3}) * 8'd7;
		ck_word = {b0, b1, b2, b3};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sm4_ram.sv =====
`default_nettype none
module sm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/sm4_block_cipher_ecb_cbc_core.sv =====
// sm4 block engine, ecb or cbc, one 128-bit block per transfer
// flow: input transfer, then 32 rounds with one key ram read each, then the output load once the
//   output register is free; when the round keys are stale they are expanded first
// accept: a new block is taken only in idle, after the previous one is loaded into the output
//   register; the 32-round loop runs over the single key ram port
// key expansion: 32 round keys and a read prefetch, at the next block after reset or any key register write
// reset: control, chaining value and config registers clear; key ram content is not cleared
`default_nettype none
module sm4_block_cipher_ecb_cbc_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire sm4_pkg::sm4_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output sm4_pkg::sm4_out_t     out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [63:0]      cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXPAND = 5'b00010,
		ST_PREP   = 5'b00100,
		ST_ROUND  = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic        cbc_q;
	logic        keys_valid_q;

	// working state of the current block
	logic [31:0]  x0_q, x1_q, x2_q, x3_q;
	logic [31:0]  k0_q, k1_q, k2_q, k3_q;
	logic [4:0]   cnt_q;
	logic         mode_q;
	logic [127:0] blk_q;
	logic [127:0] chain_q;
	logic         out_valid_q;
	logic [127:0] out_q;

	logic         in_xfer;
	logic [127:0] chain_sel;
	logic [127:0] blk_in;
	logic [127:0] x_init;
	logic [31:0]  sub_in, t_sub, key_new, blk_new;
	logic [4:0]   rd_idx, raddr;
	logic         rd_mode;
	logic [31:0]  rk;
	logic         ram_we;
	logic [127:0] res_raw, res_fin;
	logic         out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = sm4_pkg::sm4_out_t'(out_q);
	assign out_free  = !out_valid_q || out_ready;

	// chaining value as seen by this block, iv reload first
	assign chain_sel = in_data.restart_chain ? {iv_high_q, iv_low_q} : chain_q;
	assign blk_in    = {in_data.block_high, in_data.block_low};
	assign x_init    = (cbc_q && !in_data.mode) ? (blk_in ^ chain_sel) : blk_in;

	// one shared sbox word for both key schedule and rounds
	always_comb begin
		if (state_q == ST_EXPAND) begin
			sub_in = k1_q ^ k2_q ^ k3_q ^ sm4_pkg::ck_word(cnt_q);
		end else begin
			sub_in = x1_q ^ x2_q ^ x3_q ^ rk;
		end
	end

	assign t_sub   = sm4_pkg::subst(sub_in);
	assign key_new = k0_q ^ t_sub ^ sm4_pkg::rotl(t_sub, 13) ^ sm4_pkg::rotl(t_sub, 23);
	assign blk_new = x0_q ^ t_sub ^ sm4_pkg::rotl(t_sub, 2) ^ sm4_pkg::rotl(t_sub, 10)
		^ sm4_pkg::rotl(t_sub, 18) ^ sm4_pkg::rotl(t_sub, 24);

	// round key prefetch: address of the next round, reversed for decrypt (31 - i == ~i)
	assign rd_idx  = (state_q == ST_IDLE || state_q == ST_PREP) ? 5'd0 : cnt_q + 5'd1;
	assign rd_mode = (state_q == ST_IDLE) ? in_data.mode : mode_q;
	assign raddr   = rd_mode ? ~rd_idx : rd_idx;
	assign ram_we  = (state_q == ST_EXPAND);

	sm4_ram #(
		.WIDTH(32),
		.DEPTH(32)
	) u_rk_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q),
		.wdata(key_new),
		.raddr(raddr),
		.rdata(rk)
	);

	// final reverse word order, cbc decrypt xors the chaining value afterwards
	assign res_raw = {x3_q, x2_q, x1_q, x0_q};
	assign res_fin = (cbc_q && mode_q) ? (res_raw ^ chain_q) : res_raw;

	// configuration writes; the user must issue them only while no block is in flight, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
			cbc_q      <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sm4_pkg::CFG_KEY_HIGH:     key_high_q <= cfg_data;
				sm4_pkg::CFG_KEY_LOW:      key_low_q  <= cfg_data;
				sm4_pkg::CFG_IV_HIGH:      iv_high_q  <= cfg_data;
				sm4_pkg::CFG_IV_LOW:       iv_low_q   <= cfg_data;
				sm4_pkg::CFG_CHAINING_CBC: cbc_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			keys_valid_q <= 1'b0;
			cnt_q        <= '0;
			chain_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// output register: load a finished block, else free it on an output transfer
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// a key write makes the round keys stale
			if (cfg_valid && (cfg_index == sm4_pkg::CFG_KEY_HIGH
				|| cfg_index == sm4_pkg::CFG_KEY_LOW)) begin
				keys_valid_q <= 1'b0;
			end else if (state_q == ST_EXPAND && cnt_q == 5'd31) begin
				keys_valid_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						chain_q <= chain_sel;
						cnt_q   <= '0;
						state_q <= keys_valid_q ? ST_ROUND : ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold the finished block until the output register frees up
					if (out_free) begin
						if (cbc_q) begin
							chain_q <= mode_q ? blk_q : res_fin;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			{x0_q, x1_q, x2_q, x3_q} <= x_init;
			mode_q <= in_data.mode;
			blk_q  <= blk_in;
			k0_q   <= key_high_q[63:32] ^ sm4_pkg::FK0;
			k1_q   <= key_high_q[31:0]  ^ sm4_pkg::FK1;
			k2_q   <= key_low_q[63:32]  ^ sm4_pkg::FK2;
			k3_q   <= key_low_q[31:0]   ^ sm4_pkg::FK3;
		end
		if (state_q == ST_EXPAND) begin
			{k0_q, k1_q, k2_q, k3_q} <= {k1_q, k2_q, k3_q, key_new};
		end
		if (state_q == ST_ROUND) begin
			{x0_q, x1_q, x2_q, x3_q} <= {x1_q, x2_q, x3_q, blk_new};
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_fin;
		end
	end

endmodule
`default_nettype wire
